FILE: design/fes_pkg.sv
package fes_pkg;

    // Event codes carried in the mode field.
    typedef enum logic [4:0] {
        MODE_BUS_OK        = 5'd0,
        MODE_TIMEOUT       = 5'd1,
        MODE_NACK          = 5'd2,
        MODE_BUS_ERR       = 5'd3,
        MODE_SENSOR_FAIL   = 5'd4,
        MODE_SENSOR_OK     = 5'd5,
        MODE_CRC_ERR       = 5'd6,
        MODE_FRAME_OK      = 5'd7,
        MODE_OVERFLOW      = 5'd8,
        MODE_RECOVERY_OK   = 5'd9,
        MODE_RECOVERY_FAIL = 5'd10,
        MODE_WDT_RESET     = 5'd11,
        MODE_FLASH_FAIL    = 5'd12,
        MODE_FLASH_OK      = 5'd13,
        MODE_CLEAR         = 5'd14,
        MODE_DONE          = 5'd15,
        MODE_REINIT        = 5'd16,
        MODE_NONE          = 5'd17
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BUS_FAULT_LIMIT     = 3'd0,
        REG_SENSOR_FAIL_LIMIT   = 3'd1,
        REG_RECOVERY_FAIL_LIMIT = 3'd2,
        REG_OVERFLOW_LIMIT      = 3'd3,
        REG_SAVE_FAIL_LIMIT     = 3'd4
    } t_reg_idx;

    localparam int CFG_INDEX_W = 3;
    localparam int LIMIT_W     = 8;
    localparam int SEL_W       = 4;
    localparam int VALUE_W     = 8;

    // Counter slots.
    localparam int NUM_CNT       = 13;
    localparam int CNT_TMO       = 0;
    localparam int CNT_NACK      = 1;
    localparam int CNT_BUS       = 2;
    localparam int CNT_CRC       = 3;
    localparam int CNT_SENS      = 4;
    localparam int CNT_OVF       = 5;
    localparam int CNT_REC       = 6;
    localparam int CNT_WDT       = 7;
    localparam int CNT_FLASH     = 8;
    localparam int CNT_SENS_RUN  = 9;
    localparam int CNT_OVF_RUN   = 10;
    localparam int CNT_REC_RUN   = 11;
    localparam int CNT_FLASH_RUN = 12;

    // Limit values after reset.
    localparam logic [LIMIT_W-1:0] RST_BUS_FAULT_LIMIT     = 8'd5;
    localparam logic [LIMIT_W-1:0] RST_SENSOR_FAIL_LIMIT   = 8'd3;
    localparam logic [LIMIT_W-1:0] RST_RECOVERY_FAIL_LIMIT = 8'd3;
    localparam logic [LIMIT_W-1:0] RST_OVERFLOW_LIMIT      = 8'd5;
    localparam logic [LIMIT_W-1:0] RST_SAVE_FAIL_LIMIT     = 8'd3;

endpackage

FILE: design/fault_event_supervisor_top.sv
// Fault event supervisor. Each input beat carries one fault or health event and a
// counter selector; each event gives exactly one result beat with the recovery
// request, recovery done and fatal latches, the watchdog feed permission and the
// selected event counter after the event. The block takes one event per clock
// cycle while the result side drains: an input register and a result register
// bracket a single pass of counter update and limit compare logic. Limits are
// written through the configuration channel, which is always ready, and should
// be changed only while no event is in flight.
module fault_event_supervisor_top #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fes_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fes_pkg::LIMIT_W-1:0]     i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [4:0]                      i_mode,
    input  logic [fes_pkg::SEL_W-1:0]       i_counter_select,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_recovery_wanted,
    output logic                            o_recovery_finished,
    output logic                            o_fatal_latched,
    output logic                            o_feed_permitted,
    output logic [fes_pkg::VALUE_W-1:0]     o_counter_value
);
    import fes_pkg::*;

    // Compare width: wide enough for the timeout plus bus error sum and the limits.
    localparam int CMP_W = (COUNT_WIDTH + 1 > LIMIT_W + 1) ? COUNT_WIDTH + 1 : LIMIT_W + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    // Saturating increment.
    function automatic t_cnt f_bump(input t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

    // Configuration registers.
    logic [LIMIT_W-1:0] r_bus_fault_limit;
    logic [LIMIT_W-1:0] r_sensor_fail_limit;
    logic [LIMIT_W-1:0] r_recovery_fail_limit;
    logic [LIMIT_W-1:0] r_overflow_limit;
    logic [LIMIT_W-1:0] r_save_fail_limit;

    // Input stage.
    logic               r_in_valid;
    logic [4:0]         r_mode;
    logic [SEL_W-1:0]   r_sel;

    // Supervisor state.
    t_cnt               r_cnt [NUM_CNT];
    logic               r_req;
    logic               r_done;
    logic               r_fatal;

    // Result stage.
    logic               r_out_valid;
    logic               r_out_req;
    logic               r_out_done;
    logic               r_out_fatal;
    logic [VALUE_W-1:0] r_out_value;

    // Next values.
    t_cnt               n_cnt [NUM_CNT];
    logic               n_req;
    logic               n_done;
    logic               n_fatal;
    logic [VALUE_W-1:0] n_value;

    logic               out_free;
    logic               advance;
    logic               do_check;
    logic [CMP_W-1:0]   severe_sum;
    logic [CMP_W-1:0]   sel_ext;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_fault_limit     <= RST_BUS_FAULT_LIMIT;
            r_sensor_fail_limit   <= RST_SENSOR_FAIL_LIMIT;
            r_recovery_fail_limit <= RST_RECOVERY_FAIL_LIMIT;
            r_overflow_limit      <= RST_OVERFLOW_LIMIT;
            r_save_fail_limit     <= RST_SAVE_FAIL_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BUS_FAULT_LIMIT:     r_bus_fault_limit     <= i_cfg_data;
                REG_SENSOR_FAIL_LIMIT:   r_sensor_fail_limit   <= i_cfg_data;
                REG_RECOVERY_FAIL_LIMIT: r_recovery_fail_limit <= i_cfg_data;
                REG_OVERFLOW_LIMIT:      r_overflow_limit      <= i_cfg_data;
                REG_SAVE_FAIL_LIMIT:     r_save_fail_limit     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_sel  <= i_counter_select;
        end
    end

    // Counter updates for the event, then the limit check on the updated counters.
    always_comb begin
        for (int k = 0; k < NUM_CNT; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        n_req    = r_req;
        n_done   = r_done;
        n_fatal  = r_fatal;
        do_check = 1'b0;

        case (r_mode)
            MODE_BUS_OK: begin
                n_cnt[CNT_TMO]     = '0;
                n_cnt[CNT_NACK]    = '0;
                n_cnt[CNT_BUS]     = '0;
                n_cnt[CNT_REC_RUN] = '0;
            end
            MODE_TIMEOUT: begin
                n_cnt[CNT_TMO] = f_bump(r_cnt[CNT_TMO]);
                do_check       = 1'b1;
            end
            MODE_NACK: begin
                n_cnt[CNT_NACK] = f_bump(r_cnt[CNT_NACK]);
                do_check        = 1'b1;
            end
            MODE_BUS_ERR: begin
                n_cnt[CNT_BUS] = f_bump(r_cnt[CNT_BUS]);
                do_check       = 1'b1;
            end
            MODE_SENSOR_FAIL: begin
                n_cnt[CNT_SENS]     = f_bump(r_cnt[CNT_SENS]);
                n_cnt[CNT_SENS_RUN] = f_bump(r_cnt[CNT_SENS_RUN]);
                do_check            = 1'b1;
            end
            MODE_SENSOR_OK: begin
                n_cnt[CNT_SENS_RUN] = '0;
            end
            MODE_CRC_ERR: begin
                n_cnt[CNT_CRC] = f_bump(r_cnt[CNT_CRC]);
            end
            MODE_FRAME_OK: begin
                n_cnt[CNT_OVF_RUN] = '0;
            end
            MODE_OVERFLOW: begin
                n_cnt[CNT_OVF]     = f_bump(r_cnt[CNT_OVF]);
                n_cnt[CNT_OVF_RUN] = f_bump(r_cnt[CNT_OVF_RUN]);
                do_check           = 1'b1;
            end
            MODE_RECOVERY_OK: begin
                n_cnt[CNT_REC]     = f_bump(r_cnt[CNT_REC]);
                n_cnt[CNT_TMO]     = '0;
                n_cnt[CNT_BUS]     = '0;
                n_cnt[CNT_REC_RUN] = '0;
                n_req              = 1'b0;
                n_done             = 1'b1;
                do_check           = 1'b1;
            end
            MODE_RECOVERY_FAIL: begin
                n_cnt[CNT_REC]     = f_bump(r_cnt[CNT_REC]);
                n_cnt[CNT_REC_RUN] = f_bump(r_cnt[CNT_REC_RUN]);
                do_check           = 1'b1;
            end
            MODE_WDT_RESET: begin
                n_cnt[CNT_WDT] = f_bump(r_cnt[CNT_WDT]);
            end
            MODE_FLASH_FAIL: begin
                n_cnt[CNT_FLASH]     = f_bump(r_cnt[CNT_FLASH]);
                n_cnt[CNT_FLASH_RUN] = f_bump(r_cnt[CNT_FLASH_RUN]);
                do_check             = 1'b1;
            end
            MODE_FLASH_OK: begin
                n_cnt[CNT_FLASH_RUN] = '0;
            end
            MODE_CLEAR: begin
                n_req = 1'b0;
            end
            MODE_DONE: begin
                n_done = 1'b1;
                n_req  = 1'b0;
            end
            MODE_REINIT: begin
                for (int k = 0; k < NUM_CNT; k++) begin
                    n_cnt[k] = '0;
                end
                n_req   = 1'b0;
                n_done  = 1'b0;
                n_fatal = 1'b0;
            end
            default: begin
            end
        endcase

        // The sum is taken one bit wider so it cannot wrap.
        severe_sum = CMP_W'(n_cnt[CNT_TMO]) + CMP_W'(n_cnt[CNT_BUS]);
        if (do_check) begin
            if (severe_sum >= CMP_W'(r_bus_fault_limit) ||
                CMP_W'(n_cnt[CNT_SENS_RUN]) >= CMP_W'(r_sensor_fail_limit)) begin
                n_req = 1'b1;
            end
            if (CMP_W'(n_cnt[CNT_REC_RUN]) >= CMP_W'(r_recovery_fail_limit) ||
                CMP_W'(n_cnt[CNT_OVF_RUN]) >= CMP_W'(r_overflow_limit) ||
                CMP_W'(n_cnt[CNT_FLASH_RUN]) >= CMP_W'(r_save_fail_limit)) begin
                n_fatal = 1'b1;
            end
        end

        // Selected counter after the event; unused selectors read as zero.
        sel_ext = '0;
        if (r_sel < SEL_W'(NUM_CNT)) begin
            sel_ext = CMP_W'(n_cnt[r_sel]);
        end
        n_value = sel_ext[VALUE_W-1:0];
    end

    // State and result registers advance together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
            r_req       <= 1'b0;
            r_done      <= 1'b0;
            r_fatal     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                for (int k = 0; k < NUM_CNT; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
                r_req   <= n_req;
                r_done  <= n_done;
                r_fatal <= n_fatal;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_req   <= n_req;
            r_out_done  <= n_done;
            r_out_fatal <= n_fatal;
            r_out_value <= n_value;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_recovery_wanted   = r_out_req;
    assign o_recovery_finished = r_out_done;
    assign o_fatal_latched     = r_out_fatal;
    assign o_feed_permitted    = !r_out_fatal;
    assign o_counter_value     = r_out_value;

endmodule
